// ===== design/signed_int_to_radix_symbols_macros.svh =====
// assertion macros used by the signed integer to radix symbols top level
`ifndef SIGNED_INT_TO_RADIX_SYMBOLS_MACROS_SVH
`define SIGNED_INT_TO_RADIX_SYMBOLS_MACROS_SVH

// condition holds at every clock edge out of reset
`define SIRS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SIRS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SIRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sirs_pkg.sv =====
// shared types, constants and microcode table for the radix symbol converter
package sirs_pkg;

   localparam int DEF_MAX_RADIX  = 32;
   localparam int DEF_MAX_DIGITS = 32;

   localparam int VALUE_W     = 32;
   localparam int SYMBOL_W    = 8;
   localparam int RADIX_LEN_W = 6;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int NUM_SYMS    = 32;
   localparam int SYM_IDX_W   = 5;
   localparam int ALPHA_W     = NUM_SYMS * SYMBOL_W;
   localparam int DIV_BITS    = 8;
   localparam int DIV_STEPS   = VALUE_W / DIV_BITS;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int REM_CALC_W  = RADIX_LEN_W + 1;
   localparam int PC_W        = 4;

   localparam logic [SYMBOL_W-1:0]    SYM_PLUS  = 8'h2B;
   localparam logic [SYMBOL_W-1:0]    SYM_MINUS = 8'h2D;
   localparam logic [RADIX_LEN_W-1:0] MIN_RADIX = 6'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RADIX_LENGTH,
      CSR_ALPHABET_A,
      CSR_ALPHABET_B,
      CSR_ALPHABET_C,
      CSR_ALPHABET_D
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CHK_INIT,
      OP_CHK_STEP,
      OP_CHK_DONE,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_PUSH,
      OP_EMIT_SIGN,
      OP_READ,
      OP_EMIT_DIGIT
   } op_type;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_REQ,
      HOLD_RSP
   } hold_type;

   typedef enum logic [3:0] {
      J_NEVER,
      J_ALWAYS,
      J_CHECKED,
      J_CHK_MORE,
      J_NOT_OK,
      J_DIV_MORE,
      J_DIGIT_MORE,
      J_POSITIVE,
      J_EMIT_MORE
   } jcond_type;

   typedef logic [PC_W-1:0] pc_type;

   typedef struct packed {
      op_type    op;
      hold_type  hold;
      jcond_type jc;
      pc_type    target;
   } uword_type;

   localparam pc_type ST_IDLE      = 4'd0;
   localparam pc_type ST_CHK_INIT  = 4'd1;
   localparam pc_type ST_CHK_STEP  = 4'd2;
   localparam pc_type ST_CHK_DONE  = 4'd3;
   localparam pc_type ST_GO        = 4'd4;
   localparam pc_type ST_DIV_INIT  = 4'd5;
   localparam pc_type ST_DIV_STEP  = 4'd6;
   localparam pc_type ST_PUSH      = 4'd7;
   localparam pc_type ST_SIGN_TEST = 4'd8;
   localparam pc_type ST_SIGN      = 4'd9;
   localparam pc_type ST_READ      = 4'd10;
   localparam pc_type ST_EMIT      = 4'd11;
   localparam pc_type ST_DONE      = 4'd12;
   localparam pc_type ST_LAST      = ST_DONE;

   function automatic uword_type uw(op_type op, hold_type hold, jcond_type jc, pc_type target);
      uword_type w;
      w.op     = op;
      w.hold   = hold;
      w.jc     = jc;
      w.target = target;
      return w;
   endfunction

   // control store
   function automatic uword_type ucode_rom(pc_type pc);
      uword_type w;
      case (pc)
         ST_IDLE:      w = uw(OP_LOAD,       HOLD_REQ,  J_CHECKED,    ST_GO);
         ST_CHK_INIT:  w = uw(OP_CHK_INIT,   HOLD_NONE, J_NEVER,      ST_IDLE);
         ST_CHK_STEP:  w = uw(OP_CHK_STEP,   HOLD_NONE, J_CHK_MORE,   ST_CHK_STEP);
         ST_CHK_DONE:  w = uw(OP_CHK_DONE,   HOLD_NONE, J_NEVER,      ST_IDLE);
         ST_GO:        w = uw(OP_NONE,       HOLD_NONE, J_NOT_OK,     ST_IDLE);
         ST_DIV_INIT:  w = uw(OP_DIV_INIT,   HOLD_NONE, J_NEVER,      ST_IDLE);
         ST_DIV_STEP:  w = uw(OP_DIV_STEP,   HOLD_NONE, J_DIV_MORE,   ST_DIV_STEP);
         ST_PUSH:      w = uw(OP_PUSH,       HOLD_NONE, J_DIGIT_MORE, ST_DIV_INIT);
         ST_SIGN_TEST: w = uw(OP_NONE,       HOLD_NONE, J_POSITIVE,   ST_READ);
         ST_SIGN:      w = uw(OP_EMIT_SIGN,  HOLD_RSP,  J_NEVER,      ST_IDLE);
         ST_READ:      w = uw(OP_READ,       HOLD_NONE, J_NEVER,      ST_IDLE);
         ST_EMIT:      w = uw(OP_EMIT_DIGIT, HOLD_RSP,  J_EMIT_MORE,  ST_READ);
         ST_DONE:      w = uw(OP_NONE,       HOLD_NONE, J_ALWAYS,     ST_IDLE);
         default:      w = uw(OP_NONE,       HOLD_NONE, J_ALWAYS,     ST_IDLE);
      endcase
      return w;
   endfunction

   function automatic logic [SYMBOL_W-1:0] sym_at(logic [ALPHA_W-1:0] alpha,
                                                  logic [SYM_IDX_W-1:0] idx);
      return alpha[{idx, 3'b000} +: SYMBOL_W];
   endfunction

endpackage

// ===== design/sirs_if.sv =====
// request and response channel interfaces
interface sirs_req_if import sirs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sirs_rsp_if import sirs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] symbol;
   logic                last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ===== design/signed_int_to_radix_symbols.sv =====
// signed integer to radix symbol converter, microcoded top level
//
// A request carries one signed 32-bit value. The response channel returns its
// digits in the configured radix as symbol bytes, most significant first, with
// a leading '-' for negative values and last set on the final byte. With an
// invalid alphabet a request is taken and no response follows.
// The csr port writes radix_length (index 0) and the four alphabet words
// (indexes 1 to 4); write only while the converter is idle.
// Per request the sequencer loads the value, then for each digit runs one init
// step, four division steps (eight quotient bits each) and one push into the
// digit stack; after a sign step for negative values it reads each digit back
// and emits it, waiting whenever the response side stalls. The first request
// after reset or any csr write also runs the alphabet check over each used
// symbol. With an invalid alphabet a request passes the load and go steps only.
// Responses leave through an output register; when the receiver stalls the
// sequencer holds at its sign or emit step. Reset clears the configuration and
// check flags, returns the sequencer to its idle step and drops response valid.
`include "signed_int_to_radix_symbols_macros.svh"

module signed_int_to_radix_symbols import sirs_pkg::*; #(
   parameter int MAX_RADIX  = DEF_MAX_RADIX,
   parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   sirs_req_if.sink               req,
   sirs_rsp_if.source             rsp
);

   localparam int DIGIT_W = $clog2(MAX_RADIX);
   localparam int DCNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int DADDR_W = $clog2(MAX_DIGITS);

   logic [RADIX_LEN_W-1:0] radix_len_ff;
   logic [ALPHA_W-1:0]     alphabet_ff;

   pc_type    pc_ff, pc_in;
   uword_type uword;
   logic      fire;
   logic      jump;
   logic      out_free;

   logic [VALUE_W-1:0]   mag_ff;
   logic                 neg_ff;
   logic [DIGIT_W-1:0]   rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [DCNT_W-1:0]    dcnt_ff;
   logic [SYM_IDX_W-1:0] chk_idx_ff;
   logic                 bad_ff;
   logic                 checked_ff;
   logic                 ok_ff;
   logic [DIGIT_W-1:0]   rd_data_ff;
   logic [DIGIT_W-1:0]   digit_mem [MAX_DIGITS];

   logic                rsp_valid_ff;
   logic [SYMBOL_W-1:0] rsp_symbol_ff;
   logic                rsp_last_ff;

   logic [DIGIT_W-1:0]  rem_next;
   logic [DIV_BITS-1:0] quot_bits;
   logic                step_bad;
   logic [DADDR_W-1:0]  wr_addr;
   logic [DADDR_W-1:0]  rd_addr;
   logic [DCNT_W-1:0]   dcnt_dec;

   assign uword    = ucode_rom(pc_ff);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (uword.hold == HOLD_REQ);

   assign dcnt_dec = dcnt_ff - DCNT_W'(1);
   assign wr_addr  = dcnt_ff[DADDR_W-1:0];
   assign rd_addr  = dcnt_dec[DADDR_W-1:0];

   // step gating
   always_comb begin
      case (uword.hold)
         HOLD_NONE: fire = 1'b1;
         HOLD_REQ:  fire = req.valid;
         HOLD_RSP:  fire = out_free;
         default:   fire = 1'b1;
      endcase
   end

   // jump conditions, evaluated on the state before the step executes
   always_comb begin
      case (uword.jc)
         J_NEVER:      jump = 1'b0;
         J_ALWAYS:     jump = 1'b1;
         J_CHECKED:    jump = checked_ff;
         J_CHK_MORE:   jump = (chk_idx_ff != '1) &&
                              (({1'b0, chk_idx_ff} + RADIX_LEN_W'(1)) < radix_len_ff);
         J_NOT_OK:     jump = !ok_ff;
         J_DIV_MORE:   jump = (div_cnt_ff != DIV_CNT_W'(DIV_STEPS - 1));
         J_DIGIT_MORE: jump = (mag_ff != '0) && (dcnt_ff < DCNT_W'(MAX_DIGITS - 1));
         J_POSITIVE:   jump = !neg_ff;
         J_EMIT_MORE:  jump = (dcnt_ff != '0);
         default:      jump = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      pc_in = pc_ff;
      if (fire) begin
         pc_in = jump ? uword.target : pc_ff + PC_W'(1);
      end
   end

   // eight restoring division steps on the high byte of the magnitude
   always_comb begin
      logic [REM_CALC_W-1:0] t;
      t         = REM_CALC_W'(rem_ff);
      quot_bits = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
         t = {t[REM_CALC_W-2:0], mag_ff[VALUE_W-1-k]};
         if (t >= REM_CALC_W'(radix_len_ff)) begin
            t = t - REM_CALC_W'(radix_len_ff);
            quot_bits[DIV_BITS-1-k] = 1'b1;
         end
      end
      rem_next = t[DIGIT_W-1:0];
   end

   // symbol at chk_idx against sign characters and every later used symbol
   always_comb begin
      logic [SYMBOL_W-1:0] cur;
      logic                dup;
      cur = sym_at(alphabet_ff, chk_idx_ff);
      dup = 1'b0;
      for (int j = 0; j < NUM_SYMS; j++) begin
         if ((SYM_IDX_W'(j) > chk_idx_ff) && (RADIX_LEN_W'(j) < radix_len_ff) &&
             (sym_at(alphabet_ff, SYM_IDX_W'(j)) == cur)) begin
            dup = 1'b1;
         end
      end
      step_bad = ({1'b0, chk_idx_ff} < radix_len_ff) &&
                 ((cur == SYM_PLUS) || (cur == SYM_MINUS) || dup);
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= ST_IDLE;
         checked_ff   <= 1'b0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         radix_len_ff <= '0;
         alphabet_ff  <= '0;
      end else begin
         pc_ff <= pc_in;
         if (fire && (uword.op == OP_CHK_DONE)) begin
            checked_ff <= 1'b1;
            ok_ff      <= !bad_ff;
         end
         if (fire && ((uword.op == OP_EMIT_SIGN) || (uword.op == OP_EMIT_DIGIT))) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            checked_ff <= 1'b0;
            case (csr_index)
               CSR_RADIX_LENGTH: radix_len_ff <= csr_wdata[RADIX_LEN_W-1:0];
               CSR_ALPHABET_A:   alphabet_ff[0*CSR_DATA_W +: CSR_DATA_W] <= csr_wdata;
               CSR_ALPHABET_B:   alphabet_ff[1*CSR_DATA_W +: CSR_DATA_W] <= csr_wdata;
               CSR_ALPHABET_C:   alphabet_ff[2*CSR_DATA_W +: CSR_DATA_W] <= csr_wdata;
               CSR_ALPHABET_D:   alphabet_ff[3*CSR_DATA_W +: CSR_DATA_W] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (fire) begin
         case (uword.op)
            OP_LOAD: begin
               neg_ff  <= req.value[VALUE_W-1];
               // 0 - value also gives the right magnitude for the most negative input
               mag_ff  <= req.value[VALUE_W-1] ? VALUE_W'(-req.value) : VALUE_W'(req.value);
               dcnt_ff <= '0;
            end
            OP_CHK_INIT: begin
               chk_idx_ff <= '0;
               bad_ff     <= (radix_len_ff < MIN_RADIX) ||
                             (radix_len_ff > RADIX_LEN_W'(MAX_RADIX));
            end
            OP_CHK_STEP: begin
               bad_ff     <= bad_ff | step_bad;
               chk_idx_ff <= chk_idx_ff + SYM_IDX_W'(1);
            end
            OP_DIV_INIT: begin
               rem_ff     <= '0;
               div_cnt_ff <= '0;
            end
            OP_DIV_STEP: begin
               rem_ff     <= rem_next;
               mag_ff     <= {mag_ff[VALUE_W-DIV_BITS-1:0], quot_bits};
               div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
            end
            OP_PUSH: begin
               dcnt_ff <= dcnt_ff + DCNT_W'(1);
            end
            OP_READ: begin
               dcnt_ff <= dcnt_dec;
            end
            OP_EMIT_SIGN: begin
               rsp_symbol_ff <= SYM_MINUS;
               rsp_last_ff   <= 1'b0;
            end
            OP_EMIT_DIGIT: begin
               rsp_symbol_ff <= sym_at(alphabet_ff, SYM_IDX_W'(rd_data_ff));
               rsp_last_ff   <= (dcnt_ff == '0);
            end
            default: ;
         endcase
      end
   end

   // digit stack, least significant digit at the bottom
   always_ff @(posedge clock) begin
      if (fire && (uword.op == OP_PUSH)) begin
         digit_mem[wr_addr] <= rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && (uword.op == OP_READ)) begin
         rd_data_ff <= digit_mem[rd_addr];
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.symbol = rsp_symbol_ff;
   assign rsp.last   = rsp_last_ff;

   `SIRS_ASSERT_ALWAYS(a_pc_in_program, clock, reset, pc_ff <= ST_LAST,
      "sequencer left the control store")
   `SIRS_ASSERT_IMPLIES(a_digit_count_bound, clock, reset, pc_ff != ST_IDLE,
      dcnt_ff <= DCNT_W'(MAX_DIGITS), "digit stack overflow")
   `SIRS_ASSERT_IMPLIES(a_rem_below_radix, clock, reset, pc_ff == ST_PUSH,
      REM_CALC_W'(rem_ff) < REM_CALC_W'(radix_len_ff), "remainder not below radix")
   `SIRS_ASSERT_IMPLIES(a_emit_needs_valid_alphabet, clock, reset,
      uword.op == OP_EMIT_DIGIT, checked_ff && ok_ff, "digit emitted with bad alphabet")
   `SIRS_ASSERT_NEXT(a_last_digit_ends_run, clock, reset,
      fire && (uword.op == OP_EMIT_DIGIT) && (dcnt_ff == '0), pc_ff == ST_DONE,
      "run did not end after last digit")

endmodule
